/* src/efa_pkg.sv */
// Shared types, constants and helpers for the EMA-filtered Adam update block.
// Depends on nothing; every other file but efa_ram imports it.
package efa_pkg;

  // Element store geometry
  localparam int ELEM_IDX_W  = 12;
  localparam int ELEM_COUNT  = 4096;
  localparam int EPSILON_LSB = 1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_AMPLIFY_GAIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_DECAY  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M1_DECAY      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M2_DECAY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARNING_RATE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DECAY_WEIGHT  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_CORR    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SECOND_CORR   = 3'd7;

  // Fixed-point constants
  localparam logic [24:0] ONE24       = 25'h100_0000;
  localparam logic [47:0] M48         = 48'hFFFF_FFFF_FFFF;
  localparam logic [38:0] RATIO_LIMIT = 39'h40_0000_0000;

  // Iterative unit step counts (one bit or one root digit per stage)
  localparam int MHAT_STEPS  = 56;
  localparam int VHAT_STEPS  = 48;
  localparam int SQRT_STEPS  = 32;
  localparam int RATIO_STEPS = 39;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  localparam int SAT_W = 44;

  typedef struct packed {
    logic [31:0] amplify_gain;
    logic [23:0] filter_decay;
    logic [23:0] m1_decay;
    logic [23:0] m2_decay;
    logic [23:0] learning_rate;
    logic [23:0] decay_weight;
    logic [24:0] first_corr;
    logic [24:0] second_corr;
  } cfg_t;

  // Per-element stored averages
  typedef struct packed {
    logic [31:0] slow_avg;
    logic [31:0] mom1;
    logic [47:0] mom2;
  } elem_state_t;

  // Item handed from the front to the back
  typedef struct packed {
    logic [31:0] param;
    logic [31:0] grad_amp;
    logic [31:0] mom1;
    logic [47:0] mom2;
    logic        sat;
  } q_item_t;

  function automatic logic over32(input logic signed [SAT_W-1:0] x);
    return (x > 44'sd2147483647) || (x < -44'sd2147483648);
  endfunction

  function automatic logic [31:0] clamp32(input logic signed [SAT_W-1:0] x);
    logic [31:0] r;
    if (x > 44'sd2147483647) begin
      r = 32'h7FFF_FFFF;
    end else if (x < -44'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

endpackage

/* src/efa_if.sv */
// Valid/ready channel interfaces for input items and result items.
// Depends on efa_pkg.
interface efa_in_if import efa_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ELEM_IDX_W-1:0] element_index;
  logic signed [31:0]    param_value;
  logic signed [31:0]    grad_value;

  modport source (output valid, element_index, param_value, grad_value, input ready);
  modport sink   (input valid, element_index, param_value, grad_value, output ready);
endinterface

interface efa_out_if ();
  logic               valid;
  logic               ready;
  logic signed [31:0] new_param;
  logic signed [31:0] amplified_grad;
  logic               saturated;

  modport source (output valid, new_param, amplified_grad, saturated, input ready);
  modport sink   (input valid, new_param, amplified_grad, saturated, output ready);
endinterface

/* src/efa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module efa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; hold data when not reading
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

/* src/efa_front.sv */
// Front part: accepts items, clears and owns the element store, amplifies the gradient
// and updates the slow average and both moments. Depends on efa_pkg, efa_if, efa_ram.
module efa_front import efa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  efa_in_if.sink    in_i,
  output logic      q_push_o,
  output q_item_t   q_item_o,
  input  logic      q_full_i
);

  localparam int NSTG = 8;
  localparam logic [ELEM_IDX_W-1:0] LAST_IDX = ELEM_IDX_W'(ELEM_COUNT - 1);

  logic [NSTG-1:0]       vld_q;
  logic [ELEM_IDX_W-1:0] idx_q [NSTG];
  logic                  clearing_q;
  logic [ELEM_IDX_W-1:0] clr_cnt_q;

  logic f_adv, hazard, acc;
  elem_state_t rd_state, wr_state;

  // stage payload
  logic signed [31:0] p_q [NSTG];
  logic signed [31:0] g0_q, g1_q, g2_q;
  logic signed [58:0] e1_q;
  logic signed [31:0] mo1_q, mo2_q, mo3_q;
  logic [47:0]        vo1_q, vo2_q, vo3_q, vo4_q, vo5_q;
  logic signed [31:0] ema2_q, ema3_q, ema4_q, ema5_q, ema6_q, ema7_q;
  logic signed [64:0] aprod2_q;
  logic signed [31:0] ga3_q, ga4_q, ga5_q, ga6_q, ga7_q;
  logic               sat3_q, sat4_q, sat5_q, sat6_q, sat7_q;
  logic signed [58:0] mm4_q;
  logic [62:0]        sqp4_q;
  logic signed [31:0] m5_q, m6_q, m7_q;
  logic [47:0]        sq5_q;
  logic [49:0]        hi6_q, lo6_q;
  logic [47:0]        v7_q;

  // combinational stage results
  logic [24:0]        c_lamb, c_b1, c_b2;
  logic signed [58:0] e1_d, mm4_d;
  logic signed [31:0] ema2_d, m5_d;
  logic signed [64:0] aprod2_d;
  logic signed [SAT_W-1:0] ga_w;
  logic signed [65:0] aprnd;
  logic signed [63:0] sqp_w;
  logic [47:0]        sq5_d, v7_d;
  logic [49:0]        hi6_d, lo6_d;

  // Stall the whole front only when the last stage cannot hand off
  assign f_adv = !(vld_q[NSTG-1] && q_full_i);

  // Hold off an index that is still being updated in flight
  always_comb begin
    hazard = 1'b0;
    for (int k = 0; k < NSTG; k++) begin
      if (vld_q[k] && (idx_q[k] == in_i.element_index)) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_i.ready = f_adv && !hazard && !clearing_q;
  assign acc        = in_i.valid && in_i.ready;

  // Element store: clear pass after reset, then write-back from last stage
  assign wr_state = '{slow_avg: ema7_q, mom1: m7_q, mom2: v7_q};

  efa_ram #(
    .WIDTH ($bits(elem_state_t)),
    .DEPTH (ELEM_COUNT)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (clearing_q || q_push_o),
    .waddr_i (clearing_q ? clr_cnt_q : idx_q[NSTG-1]),
    .wdata_i (clearing_q ? '0 : wr_state),
    .re_i    (acc),
    .raddr_i (in_i.element_index),
    .rdata_o (rd_state)
  );

  assign q_push_o = vld_q[NSTG-1] && !q_full_i;
  assign q_item_o = '{param: p_q[NSTG-1], grad_amp: ga7_q, mom1: m7_q, mom2: v7_q,
                      sat: sat7_q};

  // Arithmetic of each stage
  always_comb begin
    c_lamb   = ONE24 - {1'b0, cfg_i.filter_decay};
    c_b1     = ONE24 - {1'b0, cfg_i.m1_decay};
    c_b2     = ONE24 - {1'b0, cfg_i.m2_decay};
    // slow average mix
    e1_d     = $signed({1'b0, cfg_i.filter_decay}) * $signed(rd_state.slow_avg)
             + $signed({1'b0, c_lamb}) * g0_q;
    // round slow average, then gain product
    ema2_d   = 32'((e1_q + 59'sd8388608) >>> 24);
    aprod2_d = $signed({1'b0, cfg_i.amplify_gain}) * ema2_d;
    // amplified gradient
    aprnd    = 66'(aprod2_q) + 66'sd8388608;
    ga_w     = SAT_W'(g2_q) + SAT_W'(aprnd >>> 24);
    // first moment mix and gradient square
    mm4_d    = $signed({1'b0, cfg_i.m1_decay}) * mo3_q + $signed({1'b0, c_b1}) * ga3_q;
    sqp_w    = ga3_q * ga3_q;
    // round first moment and square
    m5_d     = 32'((mm4_q + 59'sd8388608) >>> 24);
    sq5_d    = 48'((64'(sqp4_q) + 64'd32768) >> 16);
    // second moment mix in two halves
    hi6_d    = 50'(cfg_i.m2_decay) * 50'(vo5_q[47:24]) + 50'(c_b2) * 50'(sq5_q[47:24]);
    lo6_d    = 50'(cfg_i.m2_decay) * 50'(vo5_q[23:0]) + 50'(c_b2) * 50'(sq5_q[23:0]);
    v7_d     = 48'(hi6_q + 50'((51'(lo6_q) + 51'd8388608) >> 24));
  end

  // Control: valid bits and the clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      if (clearing_q) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
        if (clr_cnt_q == LAST_IDX) begin
          clearing_q <= 1'b0;
        end
      end
      if (f_adv) begin
        vld_q <= {vld_q[NSTG-2:0], acc};
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (f_adv) begin
      idx_q[0] <= in_i.element_index;
      p_q[0]   <= in_i.param_value;
      for (int k = 1; k < NSTG; k++) begin
        idx_q[k] <= idx_q[k-1];
        p_q[k]   <= p_q[k-1];
      end
      g0_q   <= in_i.grad_value;
      // stage 1
      g1_q   <= g0_q;
      e1_q   <= e1_d;
      mo1_q  <= rd_state.mom1;
      vo1_q  <= rd_state.mom2;
      // stage 2
      g2_q     <= g1_q;
      ema2_q   <= ema2_d;
      aprod2_q <= aprod2_d;
      mo2_q    <= mo1_q;
      vo2_q    <= vo1_q;
      // stage 3
      ema3_q <= ema2_q;
      ga3_q  <= clamp32(ga_w);
      sat3_q <= over32(ga_w);
      mo3_q  <= mo2_q;
      vo3_q  <= vo2_q;
      // stage 4
      ema4_q <= ema3_q;
      ga4_q  <= ga3_q;
      sat4_q <= sat3_q;
      mm4_q  <= mm4_d;
      sqp4_q <= sqp_w[62:0];
      vo4_q  <= vo3_q;
      // stage 5
      ema5_q <= ema4_q;
      ga5_q  <= ga4_q;
      sat5_q <= sat4_q;
      m5_q   <= m5_d;
      sq5_q  <= sq5_d;
      vo5_q  <= vo4_q;
      // stage 6
      ema6_q <= ema5_q;
      ga6_q  <= ga5_q;
      sat6_q <= sat5_q;
      m6_q   <= m5_q;
      hi6_q  <= hi6_d;
      lo6_q  <= lo6_d;
      // stage 7
      ema7_q <= ema6_q;
      ga7_q  <= ga6_q;
      sat7_q <= sat6_q;
      m7_q   <= m6_q;
      v7_q   <= v7_d;
    end
  end

endmodule

/* src/efa_queue.sv */
// Short queue between the front and the back part.
// Depends on efa_pkg.
module efa_queue import efa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t data_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_item_t data_o,
  output logic    empty_o
);

  q_item_t           mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, rd_q;
  logic [QPTR_W:0]   cnt_q;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  // Store pushed item
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/efa_back.sv */
// Back part: bias-corrected moments, square root, ratio and parameter step,
// as bit-per-stage division and root pipelines. Depends on efa_pkg, efa_if.
module efa_back import efa_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     q_empty_i,
  input  q_item_t  q_item_i,
  output logic     q_pop_o,
  efa_out_if.source out_o
);

  typedef struct packed {
    logic signed [31:0] param;
    logic signed [31:0] grad_amp;
    logic               sat;
    logic               neg;
    logic signed [31:0] wdp;
  } bcarry_t;

  localparam int VSKIP = MHAT_STEPS - VHAT_STEPS;

  logic b_adv;
  logic [24:0] bc1, bc2;

  // entry stage
  logic               p0_vld;
  logic [31:0]        p0_mag;
  logic               p0_neg, p0_vovf, p0_sat;
  logic [47:0]        p0_v;
  logic signed [31:0] p0_p, p0_ga;
  logic signed [56:0] p0_wdprod;
  logic signed [57:0] wdrnd;

  // division stages (moment quotients)
  logic [MHAT_STEPS-1:0] dvl_q;
  bcarry_t     dc_in [MHAT_STEPS], dc_q [MHAT_STEPS];
  logic [24:0] mr_in [MHAT_STEPS], mr_d [MHAT_STEPS], mr_q [MHAT_STEPS];
  logic [55:0] mq_in [MHAT_STEPS], mq_d [MHAT_STEPS], mq_q [MHAT_STEPS];
  logic [24:0] vr_in [MHAT_STEPS], vr_d [MHAT_STEPS], vr_q [MHAT_STEPS];
  logic [47:0] vq_in [MHAT_STEPS], vq_d [MHAT_STEPS], vq_q [MHAT_STEPS];
  logic        vo_in [MHAT_STEPS], vo_q [MHAT_STEPS];

  // square root stages
  logic [SQRT_STEPS-1:0] svl_q;
  bcarry_t     sc_in [SQRT_STEPS], sc_q [SQRT_STEPS];
  logic [55:0] sm_in [SQRT_STEPS], sm_q [SQRT_STEPS];
  logic [33:0] sr_in [SQRT_STEPS], sr_d [SQRT_STEPS], sr_q [SQRT_STEPS];
  logic [31:0] st_in [SQRT_STEPS], st_d [SQRT_STEPS], st_q [SQRT_STEPS];
  logic [63:0] sx_in [SQRT_STEPS], sx_q [SQRT_STEPS];

  // ratio division stages
  logic [RATIO_STEPS-1:0] rvl_q;
  bcarry_t     rc_in [RATIO_STEPS], rc_q [RATIO_STEPS];
  logic [32:0] rd_in [RATIO_STEPS], rd_q [RATIO_STEPS];
  logic        ro_in [RATIO_STEPS], ro_q [RATIO_STEPS];
  logic [32:0] rr_in [RATIO_STEPS], rr_d [RATIO_STEPS], rr_q [RATIO_STEPS];
  logic [38:0] rq_in [RATIO_STEPS], rq_d [RATIO_STEPS], rq_q [RATIO_STEPS];

  logic [47:0] vhat_w;
  logic [32:0] denom_w;
  logic [55:0] mhat_w;

  // step stages
  logic               f1_vld, f2_vld, out_vld_q;
  logic signed [40:0] f1_u;
  logic signed [31:0] f1_p, f1_ga, f2_p, f2_ga;
  logic               f1_sat, f2_sat;
  logic signed [65:0] f2_prod;
  logic               rclip;
  logic [38:0]        rmag;
  logic signed [39:0] ratio_w;
  logic signed [65:0] nprnd;
  logic signed [SAT_W-1:0] np_w;
  logic signed [31:0] out_np_q, out_ga_q;
  logic               out_sat_q;

  assign b_adv   = !out_vld_q || out_o.ready;
  assign q_pop_o = !q_empty_i && b_adv;

  // A zero correction acts as one LSB
  assign bc1 = (cfg_i.first_corr == '0) ? 25'd1 : cfg_i.first_corr;
  assign bc2 = (cfg_i.second_corr == '0) ? 25'd1 : cfg_i.second_corr;

  assign wdrnd = 58'(p0_wdprod) + 58'sd8388608;

  // Feed each division stage from the one before
  always_comb begin
    dc_in[0] = '{param: p0_p, grad_amp: p0_ga, sat: p0_sat, neg: p0_neg,
                 wdp: 32'(wdrnd >>> 24)};
    mr_in[0] = '0;
    mq_in[0] = {p0_mag, 24'b0};
    vr_in[0] = {1'b0, p0_v[47:24]};
    vq_in[0] = {p0_v[23:0], 24'b0};
    vo_in[0] = p0_vovf;
    for (int k = 1; k < MHAT_STEPS; k++) begin
      dc_in[k] = dc_q[k-1];
      mr_in[k] = mr_q[k-1];
      mq_in[k] = mq_q[k-1];
      vr_in[k] = vr_q[k-1];
      vq_in[k] = vq_q[k-1];
      vo_in[k] = vo_q[k-1];
    end
  end

  // One restoring division step per stage; the second moment starts later
  always_comb begin
    logic [25:0] mt, vt;
    for (int k = 0; k < MHAT_STEPS; k++) begin
      mt = {mr_in[k], mq_in[k][55]};
      if (mt >= {1'b0, bc1}) begin
        mr_d[k] = 25'(mt - {1'b0, bc1});
        mq_d[k] = {mq_in[k][54:0], 1'b1};
      end else begin
        mr_d[k] = mt[24:0];
        mq_d[k] = {mq_in[k][54:0], 1'b0};
      end
      vt = {vr_in[k], vq_in[k][47]};
      if (k < VSKIP) begin
        vr_d[k] = vr_in[k];
        vq_d[k] = vq_in[k];
      end else if (vt >= {1'b0, bc2}) begin
        vr_d[k] = 25'(vt - {1'b0, bc2});
        vq_d[k] = {vq_in[k][46:0], 1'b1};
      end else begin
        vr_d[k] = vt[24:0];
        vq_d[k] = {vq_in[k][46:0], 1'b0};
      end
    end
  end

  // Clip the corrected second moment, then feed the root stages
  assign vhat_w = vo_q[MHAT_STEPS-1] ? M48 : vq_q[MHAT_STEPS-1];

  always_comb begin
    sc_in[0]     = dc_q[MHAT_STEPS-1];
    sc_in[0].sat = dc_q[MHAT_STEPS-1].sat | vo_q[MHAT_STEPS-1];
    sm_in[0]     = mq_q[MHAT_STEPS-1];
    sr_in[0]     = '0;
    st_in[0]     = '0;
    sx_in[0]     = {vhat_w, 16'b0};
    for (int k = 1; k < SQRT_STEPS; k++) begin
      sc_in[k] = sc_q[k-1];
      sm_in[k] = sm_q[k-1];
      sr_in[k] = sr_q[k-1];
      st_in[k] = st_q[k-1];
      sx_in[k] = sx_q[k-1];
    end
  end

  // One root digit per stage
  always_comb begin
    logic [35:0] t;
    logic [35:0] trial;
    for (int k = 0; k < SQRT_STEPS; k++) begin
      t     = {sr_in[k], sx_in[k][63:62]};
      trial = {2'b0, st_in[k], 2'b01};
      if (t >= trial) begin
        sr_d[k] = 34'(t - trial);
        st_d[k] = {st_in[k][30:0], 1'b1};
      end else begin
        sr_d[k] = t[33:0];
        st_d[k] = {st_in[k][30:0], 1'b0};
      end
    end
  end

  // Denominator and overflow test, then feed the ratio stages
  assign denom_w = {1'b0, st_q[SQRT_STEPS-1]} + 33'(EPSILON_LSB);
  assign mhat_w  = sm_q[SQRT_STEPS-1];

  always_comb begin
    rc_in[0] = sc_q[SQRT_STEPS-1];
    rd_in[0] = denom_w;
    ro_in[0] = (mhat_w >= {8'b0, denom_w, 15'b0});
    rr_in[0] = mhat_w[47:15];
    rq_in[0] = {mhat_w[14:0], 24'b0};
    for (int k = 1; k < RATIO_STEPS; k++) begin
      rc_in[k] = rc_q[k-1];
      rd_in[k] = rd_q[k-1];
      ro_in[k] = ro_q[k-1];
      rr_in[k] = rr_q[k-1];
      rq_in[k] = rq_q[k-1];
    end
  end

  always_comb begin
    logic [33:0] t;
    for (int k = 0; k < RATIO_STEPS; k++) begin
      t = {rr_in[k], rq_in[k][38]};
      if (t >= {1'b0, rd_in[k]}) begin
        rr_d[k] = 33'(t - {1'b0, rd_in[k]});
        rq_d[k] = {rq_in[k][37:0], 1'b1};
      end else begin
        rr_d[k] = t[32:0];
        rq_d[k] = {rq_in[k][37:0], 1'b0};
      end
    end
  end

  // Clip and sign the ratio, add weight decay, take the step
  always_comb begin
    rclip   = ro_q[RATIO_STEPS-1] || (rq_q[RATIO_STEPS-1] > RATIO_LIMIT);
    rmag    = rclip ? RATIO_LIMIT : rq_q[RATIO_STEPS-1];
    ratio_w = rc_q[RATIO_STEPS-1].neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
    nprnd   = f2_prod + 66'sd8388608;
    np_w    = SAT_W'(f2_p) - SAT_W'(nprnd >>> 24);
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.new_param      = out_np_q;
  assign out_o.amplified_grad = out_ga_q;
  assign out_o.saturated      = out_sat_q;

  // Valid bits advance together
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p0_vld    <= 1'b0;
      dvl_q     <= '0;
      svl_q     <= '0;
      rvl_q     <= '0;
      f1_vld    <= 1'b0;
      f2_vld    <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (b_adv) begin
      p0_vld    <= q_pop_o;
      dvl_q     <= {dvl_q[MHAT_STEPS-2:0], p0_vld};
      svl_q     <= {svl_q[SQRT_STEPS-2:0], dvl_q[MHAT_STEPS-1]};
      rvl_q     <= {rvl_q[RATIO_STEPS-2:0], svl_q[SQRT_STEPS-1]};
      f1_vld    <= rvl_q[RATIO_STEPS-1];
      f2_vld    <= f1_vld;
      out_vld_q <= f2_vld;
    end
  end

  // Payload advances with the valid bits
  always_ff @(posedge clk_i) begin
    if (b_adv) begin
      p0_neg    <= q_item_i.mom1[31];
      p0_mag    <= q_item_i.mom1[31] ? (~q_item_i.mom1 + 32'd1) : q_item_i.mom1;
      p0_v      <= q_item_i.mom2;
      p0_vovf   <= ({1'b0, q_item_i.mom2} >= {bc2, 24'b0});
      p0_p      <= q_item_i.param;
      p0_ga     <= q_item_i.grad_amp;
      p0_sat    <= q_item_i.sat;
      p0_wdprod <= $signed({1'b0, cfg_i.decay_weight}) * $signed(q_item_i.param);
      for (int k = 0; k < MHAT_STEPS; k++) begin
        dc_q[k] <= dc_in[k];
        mr_q[k] <= mr_d[k];
        mq_q[k] <= mq_d[k];
        vr_q[k] <= vr_d[k];
        vq_q[k] <= vq_d[k];
        vo_q[k] <= vo_in[k];
      end
      for (int k = 0; k < SQRT_STEPS; k++) begin
        sc_q[k] <= sc_in[k];
        sm_q[k] <= sm_in[k];
        sr_q[k] <= sr_d[k];
        st_q[k] <= st_d[k];
        sx_q[k] <= {sx_in[k][61:0], 2'b00};
      end
      for (int k = 0; k < RATIO_STEPS; k++) begin
        rc_q[k] <= rc_in[k];
        rd_q[k] <= rd_in[k];
        ro_q[k] <= ro_in[k];
        rr_q[k] <= rr_d[k];
        rq_q[k] <= rq_d[k];
      end
      f1_u      <= 41'(ratio_w) + 41'(rc_q[RATIO_STEPS-1].wdp);
      f1_p      <= rc_q[RATIO_STEPS-1].param;
      f1_ga     <= rc_q[RATIO_STEPS-1].grad_amp;
      f1_sat    <= rc_q[RATIO_STEPS-1].sat | rclip;
      f2_prod   <= $signed({1'b0, cfg_i.learning_rate}) * f1_u;
      f2_p      <= f1_p;
      f2_ga     <= f1_ga;
      f2_sat    <= f1_sat;
      out_np_q  <= clamp32(np_w);
      out_ga_q  <= f2_ga;
      out_sat_q <= f2_sat | over32(np_w);
    end
  end

endmodule

/* src/ema_filtered_adam_update_core.sv */
// Top level of the EMA-filtered Adam update block: configuration registers,
// front, queue and back. Depends on efa_pkg, efa_if, efa_front, efa_queue, efa_back.
//
// Usage:
//   in_i carries one weight element per item: element_index, param_value and
//   grad_value. out_o returns one result per item, in order: new_param,
//   amplified_grad and saturated. Both channels use valid/ready.
//   Registers are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Pipeline: 8 front stages, queue, 56 moment-division stages, 32 root stages,
//   39 ratio-division stages, 3 step and output stages.
// Throughput: one item per cycle while the queue has room. An item whose element_index
//   matches one of the 8 items still in the front update stages waits until that item
//   has written back its averages, since the store has one read and one write port.
// Reset: all registers take their defaults and a clearing pass writes zero to
//   all 4096 store entries, one per cycle; in_i.ready stays low until the pass ends.
// Output stall: the back pipeline holds while out_o.ready is low; the queue
//   absorbs the front, which keeps accepting until the queue fills.
module ema_filtered_adam_update_core import efa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  efa_in_if.sink                in_i,
  efa_out_if.source             out_o
);

  cfg_t    cfg_q;
  logic    q_push, q_full, q_pop, q_empty;
  q_item_t q_wdata, q_rdata;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.amplify_gain  <= 32'd0;
      cfg_q.filter_decay  <= 24'd16475832;
      cfg_q.m1_decay      <= 24'd15099494;
      cfg_q.m2_decay      <= 24'd16760438;
      cfg_q.learning_rate <= 24'd0;
      cfg_q.decay_weight  <= 24'd0;
      cfg_q.first_corr    <= ONE24;
      cfg_q.second_corr   <= ONE24;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_AMPLIFY_GAIN:  cfg_q.amplify_gain  <= cfg_data_i;
        CFG_FILTER_DECAY:  cfg_q.filter_decay  <= cfg_data_i[23:0];
        CFG_M1_DECAY:      cfg_q.m1_decay      <= cfg_data_i[23:0];
        CFG_M2_DECAY:      cfg_q.m2_decay      <= cfg_data_i[23:0];
        CFG_LEARNING_RATE: cfg_q.learning_rate <= cfg_data_i[23:0];
        CFG_DECAY_WEIGHT:  cfg_q.decay_weight  <= cfg_data_i[23:0];
        CFG_FIRST_CORR:    cfg_q.first_corr    <= cfg_data_i[24:0];
        CFG_SECOND_CORR:   cfg_q.second_corr   <= cfg_data_i[24:0];
        default: ;
      endcase
    end
  end

  efa_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_i     (in_i),
    .q_push_o (q_push),
    .q_item_o (q_wdata),
    .q_full_i (q_full)
  );

  efa_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty)
  );

  efa_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .q_empty_i (q_empty),
    .q_item_i  (q_rdata),
    .q_pop_o   (q_pop),
    .out_o     (out_o)
  );

endmodule

/* dv/ema_filtered_adam_update_core_test.sv */
// Testbench for the EMA-filtered Adam update core: drives weight elements, predicts
// new parameter, amplified gradient and clip flag per element. Depends on efa_pkg, efa_if.
`timescale 1ns / 1ps

module ema_filtered_adam_update_core_test;
  import efa_pkg::*;

  typedef struct packed {
    logic [ELEM_IDX_W-1:0] idx;
    logic [31:0]           param;
    logic [31:0]           grad;
  } elem_item_t;

  typedef struct packed {
    logic [31:0] new_param;
    logic [31:0] grad_amp;
    logic        sat;
  } step_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  efa_in_if in_ch ();
  efa_out_if out_ch ();

  ema_filtered_adam_update_core dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_ch.sink), .out_o(out_ch.source)
  );

  // Predictor copy of registers and stores
  cfg_t cfg_shadow;
  logic [31:0] ema_store [ELEM_COUNT];
  logic [31:0] m1_store [ELEM_COUNT];
  logic [47:0] m2_store [ELEM_COUNT];

  elem_item_t   pending_elems[$];
  step_result_t expected_results[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off_cycles = 0;
  bit pressure_on = 1'b0;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Round to nearest, ties up: floor((v + 2^(sh-1)) / 2^sh)
  function automatic longint rnd_shift(input longint v, input int sh);
    return (v + (longint'(1) << (sh - 1))) >>> sh;
  endfunction

  // floor(n*2^24/d), clipped to lim
  function automatic logic [63:0] div_q24(input logic [63:0] n, input logic [63:0] d,
                                         input logic [63:0] lim, inout bit clip);
    logic [63:0] q1, r, q;
    q1 = n / d;
    r = n % d;
    if (q1 > (lim >> 24)) begin
      clip = 1'b1;
      return lim;
    end
    q = (q1 << 24) + ((r << 24) / d);
    if (q > lim) begin
      clip = 1'b1;
      return lim;
    end
    return q;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic longint clip32(input longint v, inout bit clip);
    if (v > 64'sd2147483647) begin
      clip = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clip = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  // Advance the stores for one element and return its expected result
  function automatic step_result_t predict_update(input elem_item_t it);
    step_result_t res;
    bit clip;
    int unsigned k;
    longint p, g, ema, ga, m, mhat, ratio, u, np;
    logic [63:0] sq, v, vhat, denom, bc1, bc2, c2, hi, lo, mag, amp, lamb, b1, b2;
    clip = 1'b0;
    k = it.idx % ELEM_COUNT;
    p = longint'(signed'(it.param));
    g = longint'(signed'(it.grad));
    lamb = cfg_shadow.filter_decay;
    ema = longint'(signed'(ema_store[k]));
    ema = rnd_shift(longint'(lamb) * ema + longint'(64'd16777216 - lamb) * g, 24);
    ema_store[k] = ema[31:0];
    amp = cfg_shadow.amplify_gain;
    ga = clip32(g + rnd_shift(longint'(amp) * ema, 24), clip);
    b1 = cfg_shadow.m1_decay;
    m = longint'(signed'(m1_store[k]));
    m = rnd_shift(longint'(b1) * m + longint'(64'd16777216 - b1) * ga, 24);
    m1_store[k] = m[31:0];
    sq = (64'(ga * ga) + 64'd32768) >> 16;
    v = m2_store[k];
    b2 = cfg_shadow.m2_decay;
    c2 = 64'd16777216 - b2;
    hi = b2 * (v >> 24) + c2 * (sq >> 24);
    lo = b2 * (v & 64'hFFFFFF) + c2 * (sq & 64'hFFFFFF);
    v = (hi + ((lo + (64'd1 << 23)) >> 24)) & 64'hFFFF_FFFF_FFFF;
    m2_store[k] = v[47:0];
    bc1 = (cfg_shadow.first_corr != 0) ? 64'(cfg_shadow.first_corr) : 64'd1;
    bc2 = (cfg_shadow.second_corr != 0) ? 64'(cfg_shadow.second_corr) : 64'd1;
    mag = (m < 0) ? 64'(-m) : 64'(m);
    mhat = longint'(div_q24(mag, bc1, 64'd1 << 58, clip));
    vhat = div_q24(v, bc2, 64'hFFFF_FFFF_FFFF, clip);
    denom = int_sqrt(vhat << 16) + EPSILON_LSB;
    ratio = longint'(div_q24(64'(mhat), denom, 64'd274877906944, clip));
    if (m < 0) ratio = -ratio;
    u = ratio + rnd_shift(longint'(64'(cfg_shadow.decay_weight)) * p, 24);
    np = clip32(p - rnd_shift(longint'(64'(cfg_shadow.learning_rate)) * u, 24), clip);
    res.new_param = np[31:0];
    res.grad_amp = ga[31:0];
    res.sat = clip;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    errors++;
    $display("MISMATCH %s: got %h expected %h (result %0d)", what, got, want, checked);
  endtask

  // Driver: offer queued elements, idle at random
  always @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      expected_results.push_back(predict_update(pending_elems.pop_front()));
      accepted++;
    end
    if ((!in_ch.valid || in_ch.ready) || !rst_ni) begin
      if (pending_elems.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_ch.valid <= 1'b1;
        in_ch.element_index <= pending_elems[0].idx;
        in_ch.param_value <= pending_elems[0].param;
        in_ch.grad_value <= pending_elems[0].grad;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Hold the receiver off for a counted stretch when asked
  always @(posedge clk_i) begin
    if (pressure_on && hold_off_cycles > 0) hold_off_cycles <= hold_off_cycles - 1;
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    step_result_t want;
    if (out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected new_param", out_ch.new_param, 32'h0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.new_param !== want.new_param)
          report_mismatch("new_param", out_ch.new_param, want.new_param);
        if (out_ch.amplified_grad !== want.grad_amp)
          report_mismatch("amplified_grad", out_ch.amplified_grad, want.grad_amp);
        if (out_ch.saturated !== want.sat)
          report_mismatch("saturated", 32'(out_ch.saturated), 32'(want.sat));
      end
      checked++;
    end
    out_ch.ready <= !(pressure_on && hold_off_cycles > 0) &&
                    ($urandom_range(99) >= recv_idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_AMPLIFY_GAIN:  cfg_shadow.amplify_gain = val;
      CFG_FILTER_DECAY:  cfg_shadow.filter_decay = val[23:0];
      CFG_M1_DECAY:      cfg_shadow.m1_decay = val[23:0];
      CFG_M2_DECAY:      cfg_shadow.m2_decay = val[23:0];
      CFG_LEARNING_RATE: cfg_shadow.learning_rate = val[23:0];
      CFG_DECAY_WEIGHT:  cfg_shadow.decay_weight = val[23:0];
      CFG_FIRST_CORR:    cfg_shadow.first_corr = val[24:0];
      CFG_SECOND_CORR:   cfg_shadow.second_corr = val[24:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain();
    while (pending_elems.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (160) @(posedge clk_i);
  endtask

  task automatic push_elem(input logic [11:0] idx, input logic [31:0] p,
                           input logic [31:0] g);
    elem_item_t it;
    it.idx = idx;
    it.param = p;
    it.grad = g;
    pending_elems.push_back(it);
  endtask

  function automatic logic [31:0] rand_q(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(2097152)) - 1048576);
      default: return 32'($signed($urandom_range(33554432)) - 16777216);
    endcase
  endfunction

  // Random settings; corrections never zero here except when chosen
  task automatic random_config(input bit extreme);
    write_reg(CFG_AMPLIFY_GAIN, extreme ? 32'hFFFF_FFFF : $urandom_range(50331648));
    write_reg(CFG_FILTER_DECAY, extreme ? 32'h0 : $urandom_range(24'hFFFFFF));
    write_reg(CFG_M1_DECAY, extreme ? 32'hFFFFFF : $urandom_range(24'hFFFFFF));
    write_reg(CFG_M2_DECAY, extreme ? 32'h0 : $urandom_range(24'hFFFFFF));
    write_reg(CFG_LEARNING_RATE, extreme ? 32'hFFFFFF : $urandom_range(24'hFFFFFF));
    write_reg(CFG_DECAY_WEIGHT, extreme ? 32'hFFFFFF : $urandom_range(24'hFFFFFF));
    write_reg(CFG_FIRST_CORR, extreme ? 32'h0 : $urandom_range(1, 25'h1000000));
    write_reg(CFG_SECOND_CORR, extreme ? 32'h1 : $urandom_range(1, 25'h1000000));
  endtask

  task automatic random_burst(input int count);
    int mode;
    for (int i = 0; i < count; i++) begin
      mode = $urandom_range(2);
      // Revisit a few hot elements often so the averages build up
      push_elem(($urandom_range(3) == 0) ? 12'($urandom()) : 12'($urandom_range(15)),
                rand_q(mode), rand_q($urandom_range(2)));
    end
  endtask

  initial begin
    cfg_shadow = '{32'd0, 24'd16475832, 24'd15099494, 24'd16760438, 24'd0, 24'd0,
                   25'd16777216, 25'd16777216};
    for (int i = 0; i < ELEM_COUNT; i++) begin
      ema_store[i] = '0;
      m1_store[i] = '0;
      m2_store[i] = '0;
    end
    in_ch.valid = 1'b0;
    in_ch.element_index = '0;
    in_ch.param_value = '0;
    in_ch.grad_value = '0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes at reset settings but a set learning rate, then extreme settings
    send_idle_pct = 9;
    recv_idle_pct = 54;
    write_reg(CFG_LEARNING_RATE, 32'h10000);
    push_elem(12'h000, 32'h0, 32'h0);
    push_elem(12'hFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_elem(12'hFFF, 32'h8000_0000, 32'h8000_0000);
    push_elem(12'hAAA, 32'h0100_0000, 32'hFF00_0000);
    push_elem(12'h555, 32'hFFFF_FFFF, 32'h0000_0001);
    drain();
    random_config(1'b1);
    write_reg(CFG_SECOND_CORR, 32'h0);
    cfg_shadow.second_corr = 25'd0;
    push_elem(12'h001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_elem(12'h001, 32'h8000_0000, 32'h8000_0000);
    push_elem(12'h002, 32'h8000_0000, 32'h7FFF_FFFF);
    push_elem(12'h003, 32'h0000_0001, 32'hFFFF_FFFF);
    push_elem(12'h003, 32'h1234_5678, 32'h0000_0000);
    drain();

    // Random phases under several settings
    for (int ph = 0; ph < 6; ph++) begin
      random_config(1'b0);
      if (ph == 3) begin
        send_idle_pct = 54;
        recv_idle_pct = 9;
      end
      if (ph == 5) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (ph == 4) begin
        hold_off_cycles = 400;
        pressure_on = 1'b1;
      end
      random_burst(320);
      drain();
      pressure_on = 1'b0;
    end

    $display("Covered %0d elements, %0d results checked, over eight register settings",
             accepted, checked);
    $display("including extreme gains, zero corrections and long output stalls.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(20 * 600000);
    $display("Timeout with %0d results outstanding", expected_results.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
